// File: design/bma_pkg.sv
// bma_pkg: shared constants and types for the boolean mask assignment block
// used by bma_csr, bma_index and boolean_mask_assign; no dependencies
`default_nettype none

package bma_pkg;

   // field widths fixed by the interface
   localparam int DATA_W  = 64;
   localparam int SIZE_W  = 17;
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 32;
   localparam int CSR_W   = 3;

   localparam int DEFAULT_MAX_EXTENT = 65536;

   // register indexes on the configuration port
   localparam logic [CSR_W-1:0] REG_ASSIGN_MODE   = 3'd0;
   localparam logic [CSR_W-1:0] REG_SCALAR_VALUE  = 3'd1;
   localparam logic [CSR_W-1:0] REG_LEADING_SIZE  = 3'd2;
   localparam logic [CSR_W-1:0] REG_MIDDLE_SIZE   = 3'd3;
   localparam logic [CSR_W-1:0] REG_TRAILING_SIZE = 3'd4;
   localparam logic [CSR_W-1:0] REG_TRUE_COUNT    = 3'd5;

   // assign modes
   localparam logic [MODE_W-1:0] MODE_SCALAR      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BROADCAST   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ELEMENTWISE = 2'd2;

   // configuration as seen by the datapath, extents already clamped
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [DATA_W-1:0]  scalar;
      logic [SIZE_W-1:0]  lead;
      logic [SIZE_W-1:0]  mid;
      logic [SIZE_W-1:0]  trail;
      logic [INDEX_W-1:0] slice_step;   // true_count * trail, mod 2^32
      logic               ready;        // slice_step is up to date
   } cfg_type;

endpackage

`default_nettype wire

// File: design/bma_csr.sv
// bma_csr: configuration registers, extent clamping and the slice step product
// depends on bma_pkg
`default_nettype none

module bma_csr #(
   parameter int MAX_EXTENT = bma_pkg::DEFAULT_MAX_EXTENT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [bma_pkg::CSR_W-1:0]  csr_index,
   input  wire logic [bma_pkg::DATA_W-1:0] csr_write_data,
   output bma_pkg::cfg_type                cfg
);

   localparam int CLAMP_W = ($clog2(MAX_EXTENT + 1) > bma_pkg::SIZE_W) ?
                            $clog2(MAX_EXTENT + 1) : bma_pkg::SIZE_W;
   localparam logic [CLAMP_W-1:0] MAX_C = CLAMP_W'(MAX_EXTENT);

   logic [bma_pkg::MODE_W-1:0]  mode_ff;
   logic [bma_pkg::DATA_W-1:0]  scalar_ff;
   logic [bma_pkg::SIZE_W-1:0]  lead_ff;
   logic [bma_pkg::SIZE_W-1:0]  mid_ff;
   logic [bma_pkg::SIZE_W-1:0]  trail_ff;
   logic [bma_pkg::SIZE_W-1:0]  tc_ff;
   logic [bma_pkg::INDEX_W-1:0] step_ff;
   logic                        ok_ff;
   logic [bma_pkg::SIZE_W-1:0]  trail_eff;
   logic [2*bma_pkg::SIZE_W-1:0] step_in;

   // zero reads as one, anything above the limit reads as the limit
   function automatic logic [bma_pkg::SIZE_W-1:0] eff_extent(
      input logic [bma_pkg::SIZE_W-1:0] s);
      logic [bma_pkg::SIZE_W-1:0] r;
      r = s;
      if (s == '0) begin
         r = bma_pkg::SIZE_W'(1);
      end else if (CLAMP_W'(s) > MAX_C) begin
         r = MAX_C[bma_pkg::SIZE_W-1:0];
      end
      return r;
   endfunction

   assign trail_eff = eff_extent(trail_ff);
   assign step_in   = tc_ff * trail_eff;

   // register file, product register and its up-to-date flag
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bma_pkg::MODE_SCALAR;
         scalar_ff <= '0;
         lead_ff   <= bma_pkg::SIZE_W'(1);
         mid_ff    <= bma_pkg::SIZE_W'(1);
         trail_ff  <= bma_pkg::SIZE_W'(1);
         tc_ff     <= '0;
         step_ff   <= '0;
         ok_ff     <= 1'b1;
      end else begin
         step_ff <= step_in[bma_pkg::INDEX_W-1:0];
         ok_ff   <= !csr_write_enable;
         if (csr_write_enable) begin
            case (csr_index)
               bma_pkg::REG_ASSIGN_MODE:   mode_ff   <= csr_write_data[bma_pkg::MODE_W-1:0];
               bma_pkg::REG_SCALAR_VALUE:  scalar_ff <= csr_write_data;
               bma_pkg::REG_LEADING_SIZE:  lead_ff   <= csr_write_data[bma_pkg::SIZE_W-1:0];
               bma_pkg::REG_MIDDLE_SIZE:   mid_ff    <= csr_write_data[bma_pkg::SIZE_W-1:0];
               bma_pkg::REG_TRAILING_SIZE: trail_ff  <= csr_write_data[bma_pkg::SIZE_W-1:0];
               bma_pkg::REG_TRUE_COUNT:    tc_ff     <= csr_write_data[bma_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.mode       = mode_ff;
   assign cfg.scalar     = scalar_ff;
   assign cfg.lead       = eff_extent(lead_ff);
   assign cfg.mid        = eff_extent(mid_ff);
   assign cfg.trail      = trail_eff;
   assign cfg.slice_step = step_ff;
   assign cfg.ready      = ok_ff;

endmodule

`default_nettype wire

// File: design/bma_index.sv
// bma_index: axis counters, incremental index bases and the per-item result logic
// depends on bma_pkg
`default_nettype none

module bma_index #(
   parameter int MAX_EXTENT = bma_pkg::DEFAULT_MAX_EXTENT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  bma_pkg::cfg_type                 cfg,
   input  wire logic                        advance,
   input  wire logic [bma_pkg::DATA_W-1:0]  data_value,
   input  wire logic                        mask_bit,
   input  wire logic                        last_element,
   output logic [bma_pkg::DATA_W-1:0]       out_value,
   output logic                             take,
   output logic [bma_pkg::INDEX_W-1:0]      source_index
);

   localparam int POS_W = $clog2(MAX_EXTENT);
   localparam int CMP_W = (POS_W + 1 > bma_pkg::SIZE_W) ? POS_W + 1 : bma_pkg::SIZE_W;

   logic [POS_W-1:0]            inner_ff, inner_in;
   logic [POS_W-1:0]            masked_ff, masked_in;
   logic [POS_W-1:0]            outer_ff, outer_in;
   logic [bma_pkg::INDEX_W-1:0] bcast_ff, bcast_in;
   logic [bma_pkg::INDEX_W-1:0] slice_ff, slice_in;
   logic [bma_pkg::INDEX_W-1:0] ew_ff, ew_in;
   logic [CMP_W-1:0]            inner_nx, masked_nx, outer_nx;
   logic                        inner_wrap, masked_wrap, outer_wrap;
   logic [bma_pkg::INDEX_W-1:0] trail_w, inner_w, slice_nx;

   assign inner_nx    = CMP_W'(inner_ff) + CMP_W'(1);
   assign masked_nx   = CMP_W'(masked_ff) + CMP_W'(1);
   assign outer_nx    = CMP_W'(outer_ff) + CMP_W'(1);
   assign inner_wrap  = inner_nx  >= CMP_W'(cfg.trail);
   assign masked_wrap = masked_nx >= CMP_W'(cfg.mid);
   assign outer_wrap  = outer_nx  >= CMP_W'(cfg.lead);
   assign trail_w     = bma_pkg::INDEX_W'(cfg.trail);
   assign inner_w     = bma_pkg::INDEX_W'(inner_ff);
   assign slice_nx    = slice_ff + cfg.slice_step;

   // result of the current item
   always_comb begin
      out_value    = data_value;
      take         = 1'b0;
      source_index = '0;
      if (mask_bit) begin
         case (cfg.mode)
            bma_pkg::MODE_SCALAR: out_value = cfg.scalar;
            bma_pkg::MODE_BROADCAST: begin
               take         = 1'b1;
               source_index = bcast_ff + inner_w;
            end
            bma_pkg::MODE_ELEMENTWISE: begin
               take         = 1'b1;
               source_index = ew_ff + inner_w;
            end
            default: ;
         endcase
      end
   end

   // counter and base advance; ew base is slice base plus rank * trail
   always_comb begin
      inner_in  = inner_ff;
      masked_in = masked_ff;
      outer_in  = outer_ff;
      bcast_in  = bcast_ff;
      slice_in  = slice_ff;
      ew_in     = ew_ff;
      if (last_element) begin
         inner_in  = '0;
         masked_in = '0;
         outer_in  = '0;
         bcast_in  = '0;
         slice_in  = '0;
         ew_in     = '0;
      end else if (inner_wrap) begin
         inner_in = '0;
         if (mask_bit) begin
            ew_in = ew_ff + trail_w;
         end
         if (masked_wrap) begin
            masked_in = '0;
            if (outer_wrap) begin
               outer_in = '0;
               bcast_in = '0;
               slice_in = '0;
               ew_in    = '0;
            end else begin
               outer_in = outer_nx[POS_W-1:0];
               bcast_in = bcast_ff + trail_w;
               slice_in = slice_nx;
               ew_in    = slice_nx;
            end
         end else begin
            masked_in = masked_nx[POS_W-1:0];
         end
      end else begin
         inner_in = inner_nx[POS_W-1:0];
      end
   end

   // state registers, moved on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff  <= '0;
         masked_ff <= '0;
         outer_ff  <= '0;
         bcast_ff  <= '0;
         slice_ff  <= '0;
         ew_ff     <= '0;
      end else if (advance) begin
         inner_ff  <= inner_in;
         masked_ff <= masked_in;
         outer_ff  <= outer_in;
         bcast_ff  <= bcast_in;
         slice_ff  <= slice_in;
         ew_ff     <= ew_in;
      end
   end

   // the item after a last item starts a fresh tensor
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && last_element |=> inner_ff == '0 && masked_ff == '0 && outer_ff == '0
         && bcast_ff == '0 && slice_ff == '0 && ew_ff == '0)
      else $error("counters not cleared after last item");

   // ew base never lags the slice base within a slice start
   a_slice_start: assert property (@(posedge clock) disable iff (reset)
      advance && !last_element && inner_wrap && masked_wrap && !outer_wrap
      |=> ew_ff == slice_ff)
      else $error("elementwise base not at slice base at slice start");

endmodule

`default_nettype wire

// File: design/boolean_mask_assign.sv
// boolean_mask_assign: top level, result register and handshake
// depends on bma_pkg, bma_csr, bma_index
//
// Usage: tensor elements arrive on the req_ channel in raster order (outer, masked,
// inner axes), each with the mask bit of its masked-axis position and a flag on the
// final element. One result per item leaves on the rsp_ channel: the element, or the
// scalar in scalar mode, or a flag plus value-tensor index in broadcast and
// elementwise modes.
// An accepted item is registered and shown on rsp_ in the cycle after it is accepted.
// Throughput is one item per cycle while rsp_ready and the configuration allow; the
// axis counters and index bases advance by one add each, and the only multiply
// (true_count times trailing extent) sits in a register fed from the configuration,
// so req_ready drops after each configuration write while that register refreshes.
// When the receiver stalls, the result register holds and req_ready follows
// rsp_ready, so a new item is taken in the same cycle the waiting result leaves.
// Reset empties the result register, clears counters and bases, and loads the
// register defaults (scalar mode, all extents one, true count zero).
`default_nettype none

module boolean_mask_assign #(
   parameter int MAX_EXTENT = bma_pkg::DEFAULT_MAX_EXTENT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [bma_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [bma_pkg::DATA_W-1:0]  csr_write_data,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [bma_pkg::DATA_W-1:0]  req_data_value,
   input  wire logic                        req_mask_bit,
   input  wire logic                        req_last_element,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bma_pkg::DATA_W-1:0]       rsp_out_value,
   output logic                             rsp_take_from_tensor,
   output logic [bma_pkg::INDEX_W-1:0]      rsp_source_index,
   output logic                             rsp_last_result
);

   bma_pkg::cfg_type            cfg;
   logic                        accept;
   logic [bma_pkg::DATA_W-1:0]  value_in;
   logic                        take_in;
   logic [bma_pkg::INDEX_W-1:0] index_in;
   logic                        valid_ff;
   logic [bma_pkg::DATA_W-1:0]  value_ff;
   logic                        take_ff;
   logic [bma_pkg::INDEX_W-1:0] index_ff;
   logic                        last_ff;

   bma_csr #(.MAX_EXTENT(MAX_EXTENT)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bma_index #(.MAX_EXTENT(MAX_EXTENT)) u_index (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .advance      (accept),
      .data_value   (req_data_value),
      .mask_bit     (req_mask_bit),
      .last_element (req_last_element),
      .out_value    (value_in),
      .take         (take_in),
      .source_index (index_in)
   );

   // take an item when the configuration is ready and the result register is free or draining
   assign req_ready = cfg.ready && (!valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff <= value_in;
         take_ff  <= take_in;
         index_ff <= index_in;
         last_ff  <= req_last_element;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_out_value        = value_ff;
   assign rsp_take_from_tensor = take_ff;
   assign rsp_source_index     = index_ff;
   assign rsp_last_result      = last_ff;

   // no index is shown without a tensor take
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_take_from_tensor |-> rsp_source_index == '0)
      else $error("source index set on an item without a take");

   // an unmasked item passes through untouched
   a_unmasked_pass: assert property (@(posedge clock) disable iff (reset)
      accept && !req_mask_bit |=> rsp_valid && !rsp_take_from_tensor
         && rsp_out_value == $past(req_data_value))
      else $error("unmasked item altered");

   // the last flag is carried to its own result
   a_last_carried: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && rsp_last_result == $past(req_last_element))
      else $error("last flag not carried");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// testbench for boolean_mask_assign: directed table, random tensors and noise, then an elementwise wrap run;
// every result checked in order against the table or a predictor of the scatter indices
// depends on bma_pkg and the design sources only
`timescale 1ns / 1ps

module testbench;
   import bma_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int WRAP_ITEMS = 33000;
   localparam int IDLE_PCT = 11;
   localparam int REPORT_LIMIT = 10;

   // codes the package does not name
   localparam logic [MODE_W-1:0] MODE_PASS = 2'd3;
   localparam logic [CSR_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      bit [DATA_W-1:0]  value;
      bit               take;
      bit [INDEX_W-1:0] index;
      bit               last;
   } scatter_result_type;

   typedef struct packed {
      bit                 is_write;
      bit [CSR_W-1:0]     sel;
      bit [DATA_W-1:0]    data;
      bit                 mask;
      bit                 last;
      bit                 typed;
      scatter_result_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DATA_W-1:0] req_data_value = '0;
   logic req_mask_bit = 1'b0;
   logic req_last_element = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_out_value;
   logic rsp_take_from_tensor;
   logic [INDEX_W-1:0] rsp_source_index;
   logic rsp_last_result;

   // predictor copy of the registers
   bit [MODE_W-1:0] mode_reg;
   bit [DATA_W-1:0] scalar_reg;
   bit [SIZE_W-1:0] lead_reg;
   bit [SIZE_W-1:0] mid_reg;
   bit [SIZE_W-1:0] trail_reg;
   bit [31:0]       true_reg;

   // predictor position and index bases
   bit [31:0] inner_at;
   bit [31:0] masked_at;
   bit [31:0] outer_at;
   bit [31:0] ranks_seen;
   bit [31:0] bcast_start;
   bit [31:0] scatter_start;

   scatter_result_type pending_results[$];
   plan_row_type plan[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int random_sent = 0;
   bit no_idle = 1'b0;
   bit writes_open = 1'b0;

   boolean_mask_assign i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_value(req_data_value),
      .req_mask_bit(req_mask_bit),
      .req_last_element(req_last_element),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_value(rsp_out_value),
      .rsp_take_from_tensor(rsp_take_from_tensor),
      .rsp_source_index(rsp_source_index),
      .rsp_last_result(rsp_last_result)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bit [31:0] clamp_extent(bit [SIZE_W-1:0] s);
      if (s == 0) return 32'd1;
      if (s > DEFAULT_MAX_EXTENT) return DEFAULT_MAX_EXTENT;
      return s;
   endfunction

   function automatic void clear_position();
      inner_at = 0;
      masked_at = 0;
      outer_at = 0;
      ranks_seen = 0;
      bcast_start = 0;
      scatter_start = 0;
   endfunction

   function automatic void reset_predictor();
      mode_reg = MODE_SCALAR;
      scalar_reg = '0;
      lead_reg = 1;
      mid_reg = 1;
      trail_reg = 1;
      true_reg = 0;
      clear_position();
   endfunction

   function automatic void load_register(bit [CSR_W-1:0] sel, bit [DATA_W-1:0] d);
      case (sel)
         REG_ASSIGN_MODE:   mode_reg = d[MODE_W-1:0];
         REG_SCALAR_VALUE:  scalar_reg = d;
         REG_LEADING_SIZE:  lead_reg = d[SIZE_W-1:0];
         REG_MIDDLE_SIZE:   mid_reg = d[SIZE_W-1:0];
         REG_TRAILING_SIZE: trail_reg = d[SIZE_W-1:0];
         REG_TRUE_COUNT:    true_reg = d[SIZE_W-1:0];
         default: ;
      endcase
   endfunction

   // expected result of one element, then step the axis counters
   function automatic scatter_result_type predict_scatter(bit [DATA_W-1:0] d, bit m, bit l);
      scatter_result_type r;
      bit [31:0] lead_n;
      bit [31:0] mid_n;
      bit [31:0] trail_n;
      lead_n = clamp_extent(lead_reg);
      mid_n = clamp_extent(mid_reg);
      trail_n = clamp_extent(trail_reg);
      r.value = d;
      r.take = 1'b0;
      r.index = '0;
      r.last = l;
      if (m) begin
         case (mode_reg)
            MODE_SCALAR: r.value = scalar_reg;
            MODE_BROADCAST: begin
               r.take = 1'b1;
               r.index = bcast_start + inner_at;
            end
            MODE_ELEMENTWISE: begin
               r.take = 1'b1;
               r.index = scatter_start + inner_at;
            end
            MODE_PASS: ;
         endcase
      end
      if (l) begin
         clear_position();
      end else if (inner_at + 1 >= trail_n) begin
         inner_at = 0;
         // rank follows the mask of the last inner element of the position
         if (m) begin
            ranks_seen += 1;
            scatter_start += trail_n;
         end
         if (masked_at + 1 >= mid_n) begin
            masked_at = 0;
            scatter_start = scatter_start - ranks_seen * trail_n + true_reg * trail_n;
            ranks_seen = 0;
            bcast_start += trail_n;
            if (outer_at + 1 >= lead_n) clear_position();
            else outer_at += 1;
         end else begin
            masked_at += 1;
         end
      end else begin
         inner_at += 1;
      end
      return r;
   endfunction

   // directed table rows
   function automatic void plan_write(bit [CSR_W-1:0] sel, bit [DATA_W-1:0] d);
      plan_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.sel = sel;
      row.data = d;
      plan.push_back(row);
   endfunction

   function automatic void plan_item(bit [DATA_W-1:0] d, bit m, bit l);
      plan_row_type row;
      row = '0;
      row.data = d;
      row.mask = m;
      row.last = l;
      plan.push_back(row);
   endfunction

   function automatic void plan_typed(bit [DATA_W-1:0] d, bit m, bit l,
                                      bit [DATA_W-1:0] v, bit tk, bit [INDEX_W-1:0] ix);
      plan_row_type row;
      row = '0;
      row.data = d;
      row.mask = m;
      row.last = l;
      row.typed = 1'b1;
      row.want = {v, tk, ix, l};
      plan.push_back(row);
   endfunction

   // wait until every expected result is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input bit [CSR_W-1:0] sel, input bit [DATA_W-1:0] d);
      if (!writes_open) settle();
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= d;
      load_register(sel, d);
      @(posedge clock);
      writes_open = 1'b1;
   endtask

   task automatic send_item(input bit [DATA_W-1:0] d, input bit m, input bit l,
                            input bit typed, input scatter_result_type want);
      scatter_result_type predicted;
      if (writes_open) begin
         csr_write_enable <= 1'b0;
         writes_open = 1'b0;
      end
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data_value <= d;
      req_mask_bit <= m;
      req_last_element <= l;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predicted = predict_scatter(d, m, l);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic send(input bit [DATA_W-1:0] d, input bit m, input bit l);
      send_item(d, m, l, 1'b0, '0);
   endtask

   function automatic bit [SIZE_W-1:0] draw_extent();
      int roll;
      bit [SIZE_W-1:0] s;
      roll = $urandom_range(99);
      if (roll < 6) s = 0;
      else if (roll < 12) s = $urandom_range(65536, 131071);
      else s = $urandom_range(1, 6);
      return s;
   endfunction

   // size field with random junk above it
   function automatic bit [DATA_W-1:0] pad_field(bit [SIZE_W-1:0] v);
      bit [DATA_W-1:0] r;
      r = {$urandom, $urandom};
      r[SIZE_W-1:0] = v;
      return r;
   endfunction

   // one configuration, then whole tensors or noise
   task automatic random_phase();
      bit [SIZE_W-1:0] lead;
      bit [SIZE_W-1:0] mid;
      bit [SIZE_W-1:0] trail;
      bit [SIZE_W-1:0] truth;
      bit [31:0] lead_n;
      bit [31:0] mid_n;
      bit [31:0] trail_n;
      bit [15:0] slice_mask;
      bit shapely;
      bit closing;
      bit stopped;
      bit l;
      int ones;
      int total;
      int cut;
      int k;
      int n;
      lead = draw_extent();
      mid = draw_extent();
      trail = draw_extent();
      lead_n = clamp_extent(lead);
      mid_n = clamp_extent(mid);
      trail_n = clamp_extent(trail);
      slice_mask = $urandom;
      shapely = lead_n <= 6 && mid_n <= 6 && trail_n <= 6 && $urandom_range(99) < 85;
      ones = 0;
      if (mid_n <= 16) begin
         for (k = 0; k < mid_n; k++) ones += slice_mask[k];
      end
      truth = ones;
      if ($urandom_range(99) < 15) truth = $urandom;

      write_register(REG_ASSIGN_MODE, {$urandom, $urandom});
      write_register(REG_SCALAR_VALUE, {$urandom, $urandom});
      write_register(REG_LEADING_SIZE, pad_field(lead));
      write_register(REG_MIDDLE_SIZE, pad_field(mid));
      write_register(REG_TRAILING_SIZE, pad_field(trail));
      write_register(REG_TRUE_COUNT, pad_field(truth));

      if (shapely) begin
         // raster order, mask repeated over every outer slice
         total = lead_n * mid_n * trail_n;
         repeat ($urandom_range(1, 3)) begin
            cut = ($urandom_range(99) < 10) ? $urandom_range(0, total - 1) : -1;
            closing = $urandom_range(99) < 85;
            stopped = 1'b0;
            for (k = 0; k < total && !stopped; k++) begin
               l = (k == total - 1 && closing) || k == cut;
               stopped = k == cut;
               send({$urandom, $urandom}, slice_mask[(k / trail_n) % mid_n], l);
               random_sent++;
            end
         end
      end else begin
         // noise, with a stray last now and then
         n = $urandom_range(8, 40);
         for (k = 0; k < n; k++) begin
            l = k == n - 1 || $urandom_range(11) == 0;
            send({$urandom, $urandom}, $urandom_range(1), l);
            random_sent++;
         end
      end
   endtask

   // result side: random stalls, in-order compare
   always @(posedge clock) begin : result_check
      scatter_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: value %h take %b index %h last %b",
                        rsp_out_value, rsp_take_from_tensor, rsp_source_index,
                        rsp_last_result);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_value !== want.value || rsp_take_from_tensor !== want.take ||
                rsp_source_index !== want.index || rsp_last_result !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch at cycle %0d", cycle_count);
                  $display("  expected value %h take %b index %h last %b",
                           want.value, want.take, want.index, want.last);
                  $display("  actual   value %h take %b index %h last %b",
                           rsp_out_value, rsp_take_from_tensor, rsp_source_index,
                           rsp_last_result);
               end
            end
         end
      end
      rsp_ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
   end

   initial begin
      int k;
      int phase_no;
      reset_predictor();

      // after reset: scalar mode, scalar zero, all extents one
      plan_typed(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
      plan_typed(64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0, 64'h0, 1'b0, 0);
      plan_typed(64'h0, 1'b1, 1'b1, 64'h0, 1'b0, 0);
      // scalar all ones
      plan_write(REG_SCALAR_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
      plan_typed(64'h0, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
      plan_typed(64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0, 0);
      // mode three passes every element unchanged
      plan_write(REG_ASSIGN_MODE, {{62{1'b1}}, MODE_PASS});
      plan_write(REG_SCALAR_VALUE, 64'h5555_5555_5555_5555);
      plan_typed(64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1'b0, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 0);
      plan_typed(64'h0, 1'b1, 1'b1, 64'h0, 1'b0, 0);
      // broadcast over 2 x 1 x 3, zero middle extent taken as one
      plan_write(REG_ASSIGN_MODE, {62'd0, MODE_BROADCAST});
      plan_write(REG_LEADING_SIZE, 64'd2);
      plan_write(REG_MIDDLE_SIZE, 64'd0);
      plan_write(REG_TRAILING_SIZE, 64'd3);
      plan_write(REG_TRUE_COUNT, 64'd1);
      for (k = 0; k < 6; k++)
         plan_typed(64'h8000_0000_0000_0000 + k, 1'b1, k == 5,
                    64'h8000_0000_0000_0000 + k, 1'b1, k);
      // elementwise over 2 x 2 x 2 with mask 1,0
      plan_write(REG_ASSIGN_MODE, {62'd0, MODE_ELEMENTWISE});
      plan_write(REG_MIDDLE_SIZE, 64'd2);
      plan_write(REG_TRAILING_SIZE, 64'd2);
      for (k = 0; k < 8; k++) plan_item({$urandom, $urandom}, k[1] == 1'b0, k == 7);
      // unused index ignored, extents above the maximum clamped
      plan_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      plan_write(REG_LEADING_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
      plan_write(REG_MIDDLE_SIZE, 64'h1_0000);
      plan_write(REG_TRAILING_SIZE, 64'h1_0001);
      plan_write(REG_TRUE_COUNT, 64'h1_FFFF);
      for (k = 0; k < 3; k++) plan_item({$urandom, $urandom}, 1'b1, k == 2);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write) write_register(plan[i].sel, plan[i].data);
         else send_item(plan[i].data, plan[i].mask, plan[i].last, plan[i].typed, plan[i].want);
      end

      phase_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase_no++;
         no_idle = phase_no >= 12 && phase_no < 20;
         random_phase();
      end

      // elementwise base grows by 131071 per item and wraps past 2^32
      no_idle = 1'b0;
      write_register(REG_ASSIGN_MODE, {62'd0, MODE_ELEMENTWISE});
      write_register(REG_LEADING_SIZE, 64'h1_0000);
      write_register(REG_MIDDLE_SIZE, 64'd1);
      write_register(REG_TRAILING_SIZE, 64'd1);
      write_register(REG_TRUE_COUNT, 64'h1_FFFF);
      for (k = 0; k < WRAP_ITEMS; k++) begin
         no_idle = k < WRAP_ITEMS / 2;
         send({$urandom, $urandom}, $urandom_range(7) != 0, k == WRAP_ITEMS - 1);
      end
      no_idle = 1'b0;

      settle();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
